@@ hdl/rlht_pkg.sv @@
package rlht_pkg;

  // Angles are in 1/128 degree; the CORDIC accumulator works in 2^-15 degree.
  localparam int ANGLE_ITERATIONS = 16;
  localparam int TABLE_LEN        = 24;
  localparam int FULL_TURN        = 46080;
  localparam int HALF_TURN        = 23040;
  localparam int Z_START          = 180 * 32768;
  localparam int ROUND_ADD        = 128;
  localparam int ROUND_SHIFT      = 8;
  localparam int SCALE_SHIFT      = 8;

  // Turn step = floor(turn_rate * elapsed_us / 1000000), at most 4294.
  // Divide by 64 with a shift, then by 15625 with a reciprocal multiply:
  // floor(q * RECIP_MUL / 2^RECIP_SHIFT) is exact for every 26-bit q.
  localparam int STEP_W      = 13;
  localparam int PROD_W      = 32;
  localparam int STEP_PRE    = 6;
  localparam int RECIP_W     = 27;
  localparam int RECIP_MUL   = 70368745;
  localparam int RECIP_SHIFT = 40;

  localparam int XY_W = 25;
  localparam int Z_W  = 26;
  localparam int ZR_W = Z_W - ROUND_SHIFT;

  localparam int N_LOOP = ANGLE_ITERATIONS;
  localparam int ITER_W = $clog2(N_LOOP);

  typedef enum logic [1:0] {
    CFG_CENTER_X  = 2'd0,
    CFG_CENTER_Y  = 2'd1,
    CFG_TURN_RATE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_ROUND,
    ST_DIFF,
    ST_TURN
  } state_e;

  typedef struct packed {
    logic signed [11:0] target_x;
    logic signed [11:0] target_y;
    logic [15:0]        elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [15:0] heading;
    logic [15:0] target_bearing;
  } out_item_t;

  typedef struct packed {
    logic              load;
    logic              iter;
    logic [ITER_W-1:0] idx;
    logic              round;
    logic              diff;
    logic              turn;
  } dp_cmd_t;

  // atan(2^-i) in 2^-15 degree units
  function automatic logic signed [Z_W-1:0] atan_angle(input logic [4:0] i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      5'd0:  a = Z_W'(1474560);
      5'd1:  a = Z_W'(870485);
      5'd2:  a = Z_W'(459940);
      5'd3:  a = Z_W'(233473);
      5'd4:  a = Z_W'(117189);
      5'd5:  a = Z_W'(58653);
      5'd6:  a = Z_W'(29333);
      5'd7:  a = Z_W'(14667);
      5'd8:  a = Z_W'(7334);
      5'd9:  a = Z_W'(3667);
      5'd10: a = Z_W'(1833);
      5'd11: a = Z_W'(917);
      5'd12: a = Z_W'(458);
      5'd13: a = Z_W'(229);
      5'd14: a = Z_W'(115);
      5'd15: a = Z_W'(57);
      5'd16: a = Z_W'(29);
      5'd17: a = Z_W'(14);
      5'd18: a = Z_W'(7);
      5'd19: a = Z_W'(4);
      5'd20: a = Z_W'(2);
      5'd21: a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/rlht_ctrl.sv @@
module rlht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rlht_pkg::dp_cmd_t cmd_o
);

  rlht_pkg::state_e               state_q, state_d;
  logic [rlht_pkg::ITER_W-1:0]    cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic                           last_iter;
  logic                           turn_fire;

  assign last_iter = (cnt_q == rlht_pkg::ITER_W'(rlht_pkg::N_LOOP - 1));
  // The result register may be reloaded once its item leaves.
  assign turn_fire = (state_q == rlht_pkg::ST_TURN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      rlht_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = rlht_pkg::ST_ITER;
      end
      rlht_pkg::ST_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (last_iter) state_d = rlht_pkg::ST_ROUND;
      end
      rlht_pkg::ST_ROUND: state_d = rlht_pkg::ST_DIFF;
      rlht_pkg::ST_DIFF:  state_d = rlht_pkg::ST_TURN;
      rlht_pkg::ST_TURN: begin
        if (turn_fire) state_d = rlht_pkg::ST_IDLE;
      end
      default: state_d = rlht_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.idx   = cnt_q;
    cmd_o.load  = (state_q == rlht_pkg::ST_IDLE) && in_valid_i;
    cmd_o.iter  = (state_q == rlht_pkg::ST_ITER);
    cmd_o.round = (state_q == rlht_pkg::ST_ROUND);
    cmd_o.diff  = (state_q == rlht_pkg::ST_DIFF);
    cmd_o.turn  = turn_fire;
    in_stall_o  = (state_q != rlht_pkg::ST_IDLE);
  end

  assign out_valid_d = turn_fire || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlht_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/rlht_dp.sv @@
module rlht_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  rlht_pkg::in_item_t  in_item_i,
  input  rlht_pkg::dp_cmd_t   cmd_i,
  output rlht_pkg::out_item_t out_item_o
);

  localparam int XW = rlht_pkg::XY_W;
  localparam int ZW = rlht_pkg::Z_W;
  localparam int RW = rlht_pkg::ZR_W;
  localparam int PW = rlht_pkg::PROD_W;
  localparam int QW = rlht_pkg::STEP_W;
  localparam int NW = PW - rlht_pkg::STEP_PRE;
  localparam int MW = NW + rlht_pkg::RECIP_W;
  localparam logic [MW-1:0] RECIP_C = MW'(rlht_pkg::RECIP_MUL);

  logic [10:0] cx_q, cy_q;
  logic [15:0] rate_q;

  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic [QW-1:0]        step_q, step_d;
  logic [15:0]          bearing_q, bearing_d;
  logic [15:0]          diff_q, diff_d;
  logic [15:0]          heading_q, heading_d;
  rlht_pkg::out_item_t  out_q;

  // load-cycle signals
  logic signed [12:0]   dx, dy, dxa, dya;
  logic [PW-1:0]        prod;
  // iteration signals
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;
  // turn step signals
  logic [NW-1:0]        prod_hi;
  logic [MW-1:0]        recip;
  // finishing signals
  logic signed [ZW-1:0] zsum, zshift;
  logic signed [RW-1:0] zr;
  logic [16:0]          dd, hup, hdn;
  logic [15:0]          arc_dist, turn_amt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= 11'd400;
      cy_q   <= 11'd300;
      rate_q <= 16'd1920;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rlht_pkg::CFG_CENTER_X:  cx_q   <= cfg_data_i[10:0];
        rlht_pkg::CFG_CENTER_Y:  cy_q   <= cfg_data_i[10:0];
        rlht_pkg::CFG_TURN_RATE: rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx   = signed'({in_item_i.target_x[11], in_item_i.target_x}) - signed'({2'b00, cx_q});
    dy   = signed'({in_item_i.target_y[11], in_item_i.target_y}) - signed'({2'b00, cy_q});
    dxa  = dx[12] ? -dx : dx;
    dya  = dx[12] ? -dy : dy;
    prod = PW'(rate_q) * PW'(in_item_i.elapsed_us);

    xs   = x_q >>> cmd_i.idx;
    ys   = y_q >>> cmd_i.idx;
    ang  = rlht_pkg::atan_angle(5'(cmd_i.idx));

    // divide by 64, then by 15625 through the reciprocal
    prod_hi = prod_q[PW-1:rlht_pkg::STEP_PRE];
    recip   = MW'(prod_hi) * RECIP_C;

    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    prod_d = prod_q;
    step_d = step_q;
    if (cmd_i.load) begin
      x_d    = XW'(dxa) <<< rlht_pkg::SCALE_SHIFT;
      y_d    = XW'(dya) <<< rlht_pkg::SCALE_SHIFT;
      z_d    = dx[12] ? ZW'(rlht_pkg::Z_START) : '0;
      prod_d = prod;
    end else if (cmd_i.iter) begin
      // rotate toward the x axis; hold when already on it
      if (!y_q[XW-1] && (y_q != '0)) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + ang;
      end else if (y_q[XW-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - ang;
      end
    end
    if (cmd_i.round) step_d = recip[rlht_pkg::RECIP_SHIFT +: QW];
  end

  always_comb begin
    zsum      = z_q + ZW'(rlht_pkg::ROUND_ADD);
    zshift    = zsum >>> rlht_pkg::ROUND_SHIFT;
    zr        = zshift[RW-1:0];
    bearing_d = zr[RW-1] ? 16'(zr + RW'(rlht_pkg::FULL_TURN)) : 16'(zr);

    dd     = {1'b0, bearing_q} - {1'b0, heading_q};
    diff_d = dd[16] ? 16'(dd + 17'(rlht_pkg::FULL_TURN)) : dd[15:0];

    // shortest arc; exactly half a turn goes the increasing way
    arc_dist = (diff_q <= 16'(rlht_pkg::HALF_TURN)) ? diff_q
             : 16'(rlht_pkg::FULL_TURN) - diff_q;
    turn_amt = (16'(step_q) < arc_dist) ? 16'(step_q) : arc_dist;
    hup      = {1'b0, heading_q} + {1'b0, turn_amt};
    hdn      = {1'b0, heading_q} - {1'b0, turn_amt};
    if (diff_q <= 16'(rlht_pkg::HALF_TURN)) begin
      heading_d = (hup >= 17'(rlht_pkg::FULL_TURN)) ? 16'(hup - 17'(rlht_pkg::FULL_TURN))
                : hup[15:0];
    end else begin
      heading_d = hdn[16] ? 16'(hdn + 17'(rlht_pkg::FULL_TURN)) : hdn[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    prod_q <= prod_d;
    step_q <= step_d;
    if (cmd_i.round) bearing_q <= bearing_d;
    if (cmd_i.diff)  diff_q    <= diff_d;
    if (cmd_i.turn) begin
      out_q.heading        <= heading_d;
      out_q.target_bearing <= bearing_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
    end else if (cmd_i.turn) begin
      heading_q <= heading_d;
    end
  end

  assign out_item_o = out_q;

endmodule

@@ hdl/rate_limited_heading_tracker.sv @@
// Rate-limited heading tracker.
// Input channel (in_valid_i / in_stall_o / in_item_i): a target point and the
// time since the last update. The block takes the bearing from the configured
// pivot to the target (CORDIC atan2, 1/128 degree, 0 to under 360 degrees) and
// turns its stored heading toward it along the shorter arc, by at most
// turn_rate * elapsed_us / 1e6, never past the bearing.
// Output channel (out_valid_o / out_stall_i / out_item_o): new heading and the
// bearing, one item for each input item.
// Sequence: 16 CORDIC iterations, then round with the turn step multiply,
// arc difference and turn. The block takes no new item while one is in
// work; the next item is taken the cycle after the turn.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i): 0 center_x, 1 center_y,
// 2 turn_rate; other indexes are ignored. Write only while the block is idle.
// Reset: pivot (400, 300), turn_rate 1920, heading zero, no item pending.
// Receiver stall: the result holds in the output register; the block still
// takes and works one more item, then waits at the turn until the output
// register frees.
module rate_limited_heading_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rlht_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rlht_pkg::out_item_t out_item_o
);

  rlht_pkg::dp_cmd_t cmd;

  // Sequence load, iterate, round, difference and turn.
  rlht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Hold config, heading, CORDIC vector, turn step and the result register.
  rlht_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .out_item_o (out_item_o)
  );

endmodule

@@ tb/rlht_track_checker.sv @@
module rlht_track_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rlht_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rlht_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam logic [10:0] PIVOT_X_RST = 11'd400;
  localparam logic [10:0] PIVOT_Y_RST = 11'd300;
  localparam logic [15:0] RATE_RST    = 16'd1920;

  // atan(2^-i) in 2^-15 degree
  longint atan_step [0:23] = '{
    1474560, 870485, 459940, 233473, 117189, 58653, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  logic [10:0]         pivot_x;
  logic [10:0]         pivot_y;
  logic [15:0]         rate;
  logic [15:0]         heading_q;
  rlht_pkg::out_item_t track_q [$];
  rlht_pkg::out_item_t next_track;
  rlht_pkg::out_item_t want;
  int                  fails;

  assign fail_count_o = fails;
  assign pending_o    = track_q.size();

  // Bearing from pivot to target, then the capped shortest-arc turn.
  function automatic rlht_pkg::out_item_t predict_track(rlht_pkg::in_item_t it,
                                                        logic [10:0] cx, logic [10:0] cy,
                                                        logic [15:0] turn, logic [15:0] hdg);
    longint dx, dy, x, y, z, xs, ys, brg, step, h, d, s;
    rlht_pkg::out_item_t res;
    dx = longint'(it.target_x) - longint'(cx);
    dy = longint'(it.target_y) - longint'(cy);
    if (dx == 0 && dy == 0) begin
      brg = 0;
    end else begin
      z = 0;
      if (dx < 0) begin
        dx = -dx;
        dy = -dy;
        z  = longint'(rlht_pkg::HALF_TURN) * 256;
      end
      x = dx * 256;
      y = dy * 256;
      for (int i = 0; i < rlht_pkg::ANGLE_ITERATIONS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step[i];
        end else if (y < 0) begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step[i];
        end
      end
      brg = (z + 128) >>> 8;
      while (brg < 0) brg = brg + rlht_pkg::FULL_TURN;
      while (brg >= rlht_pkg::FULL_TURN) brg = brg - rlht_pkg::FULL_TURN;
    end
    step = (longint'(turn) * longint'(it.elapsed_us)) / 1000000;
    h = longint'(hdg) % rlht_pkg::FULL_TURN;
    d = (brg + rlht_pkg::FULL_TURN - h) % rlht_pkg::FULL_TURN;
    if (d != 0) begin
      if (d <= rlht_pkg::HALF_TURN) begin
        s = (step < d) ? step : d;
        h = (h + s) % rlht_pkg::FULL_TURN;
      end else begin
        s = (step < rlht_pkg::FULL_TURN - d) ? step : rlht_pkg::FULL_TURN - d;
        h = (h + rlht_pkg::FULL_TURN - s) % rlht_pkg::FULL_TURN;
      end
    end
    res.heading        = 16'(h);
    res.target_bearing = 16'(brg);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x   <= PIVOT_X_RST;
      pivot_y   <= PIVOT_Y_RST;
      rate      <= RATE_RST;
      heading_q <= '0;
      track_q.delete();
      fails     = 0;
    end else begin
      if (cfg_we_i) begin
        case (rlht_pkg::cfg_idx_e'(cfg_idx_i))
          rlht_pkg::CFG_CENTER_X:  pivot_x <= cfg_data_i[10:0];
          rlht_pkg::CFG_CENTER_Y:  pivot_y <= cfg_data_i[10:0];
          rlht_pkg::CFG_TURN_RATE: rate    <= cfg_data_i;
          default: ;
        endcase
      end
      // Retire before predicting: a result can never belong to this edge's item.
      if (out_valid_i && !out_stall_i) begin
        if (track_q.size() == 0) begin
          $error("result item with no prediction pending: heading %0d bearing %0d",
                 out_item_i.heading, out_item_i.target_bearing);
          fails++;
        end else begin
          want = track_q.pop_front();
          if (out_item_i.heading !== want.heading) begin
            $error("heading: expected %0d, actual %0d", want.heading, out_item_i.heading);
            fails++;
          end
          if (out_item_i.target_bearing !== want.target_bearing) begin
            $error("target_bearing: expected %0d, actual %0d",
                   want.target_bearing, out_item_i.target_bearing);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        next_track = predict_track(in_item_i, pivot_x, pivot_y, rate, heading_q);
        track_q.push_back(next_track);
        heading_q <= next_track.heading;
      end
    end
  end

endmodule

@@ tb/tb_rate_limited_heading_tracker.sv @@
module tb_rate_limited_heading_tracker;

  // Unlisted register index; writes to it must leave every setting alone.
  localparam logic [1:0] CFG_SPARE   = 2'd3;
  // Watchdog cycle limit, with a wide margin over the slowest legal run.
  localparam int         CYCLE_LIMIT = 900000;
  localparam int         PHASE_ITEMS = 188;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [15:0]         cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  rlht_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  rlht_pkg::out_item_t out_item_o;

  int          fail_count;
  int          pending;
  int          cycle_cnt;
  int          stall_burst;
  bit          calm;         // set to suppress idling on both sides
  logic [10:0] pivot_x;      // mirror of the programmed pivot, for near-pivot targets
  logic [10:0] pivot_y;

  rate_limited_heading_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  rlht_track_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end a hung run.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stall, occasional long stall bursts; while calm, only a burst already under way stalls.
  initial begin
    out_stall_i <= 1'b0;
    stall_burst = 0;
    forever begin
      @(posedge clk_i);
      if (stall_burst > 0) begin
        out_stall_i <= 1'b1;
        stall_burst--;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(199) == 0) begin
        stall_burst = $urandom_range(40, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < 28);
      end
    end
  end

  // Write one register; leaves the enable high for a following write.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Program pivot and rate. Pad the center writes with junk upper bits and
  // hit the spare index so masking and ignored writes get exercised too.
  task automatic configure(logic [10:0] cx, logic [10:0] cy, logic [15:0] turn);
    write_reg(rlht_pkg::CFG_CENTER_X, {5'($urandom), cx});
    write_reg(rlht_pkg::CFG_CENTER_Y, {5'($urandom), cy});
    write_reg(rlht_pkg::CFG_TURN_RATE, turn);
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_we_i <= 1'b0;
    pivot_x = cx;
    pivot_y = cy;
    @(posedge clk_i);
  endtask

  // Offer one item, at times after a random idle gap (never while calm), and hold it until taken.
  task automatic send(logic [11:0] tx, logic [11:0] ty, logic [15:0] el);
    rlht_pkg::in_item_t it;
    int                 gap;
    it.target_x   = tx;
    it.target_y   = ty;
    it.elapsed_us = el;
    gap = 0;
    if (!calm && $urandom_range(99) < 28)
      gap = ($urandom_range(9) == 0) ? $urandom_range(30, 4) : $urandom_range(3, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every predicted item has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Mostly target-tracking runs: hold one target for a few frames so the
  // heading actually converges, with a mix of frame times; the rest is
  // fully random noise.
  task automatic random_phase(int n_items, int calm_from, int calm_to);
    int          sent;
    int          mode;
    int          len;
    logic [11:0] tx;
    logic [11:0] ty;
    logic [15:0] el;
    sent = 0;
    while (sent < n_items) begin
      calm = (sent >= calm_from && sent < calm_to);
      mode = $urandom_range(9);
      if (mode < 8) begin
        tx = 12'($urandom);
        ty = 12'($urandom);
        if (mode >= 6) begin
          // Land on or next to the pivot and its axes.
          tx = 12'(int'(pivot_x) + int'($urandom_range(4)) - 2);
          ty = 12'(int'(pivot_y) + int'($urandom_range(4)) - 2);
          if ($urandom_range(1) == 0) ty = 12'(pivot_y);
          else if ($urandom_range(1) == 0) tx = 12'(pivot_x);
        end
        len = $urandom_range(8, 1);
        repeat (len) begin
          case ($urandom_range(4))
            0:       el = 16'($urandom);
            1:       el = 16'(16667 + int'($urandom_range(20)) - 10);
            2:       el = 16'hFFFF;
            3:       el = 16'($urandom_range(100));
            default: el = 16'($urandom_range(40000, 10000));
          endcase
          send(tx, ty, el);
          sent++;
        end
      end else begin
        send(12'($urandom), 12'($urandom), 16'($urandom));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= rlht_pkg::CFG_CENTER_X;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    calm       = 1'b0;
    pivot_x    = 11'd400;
    pivot_y    = 11'd300;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: pivot (400, 300), rate 1920, heading zero.
    send(12'd0, 12'd300, 16'd30000);         // dead left: exactly opposite, turn positive
    send(12'd400, 12'd300, 16'hFFFF);        // on the pivot: bearing zero, turn back
    send(12'd400, 12'd300, 16'd1000);        // heading already on the bearing
    send(12'd800, 12'd300, 16'd0);           // on the x axis, no time elapsed
    send(12'd400, 12'sd2047, 16'hFFFF);      // straight up the y axis
    send(12'd400, 12'h800, 16'hFFFF);        // straight down
    send(12'h800, 12'h800, 16'hFFFF);        // field extremes in all four corners
    send(12'sd2047, 12'sd2047, 16'hFFFF);
    send(12'sd2047, 12'h800, 16'd12345);
    send(12'h800, 12'sd2047, 16'd50000);
    send(12'hFFF, 12'hFFF, 16'd1);
    drain();

    // Zero pivot and zero rate: heading must stay put.
    configure(11'd0, 11'd0, 16'd0);
    send(12'sd2047, 12'd0, 16'hFFFF);
    send(12'h800, 12'd0, 16'hFFFF);          // negative x on the axis: exactly 180
    send(12'd0, 12'd0, 16'hFFFF);
    drain();

    // Far pivot, top rate: large steps capped by the shortest arc.
    configure(11'd2047, 11'd2047, 16'hFFFF);
    send(12'h800, 12'h800, 16'hFFFF);
    send(12'h800, 12'h800, 16'hFFFF);
    send(12'h800, 12'h800, 16'hFFFF);
    send(12'h800, 12'h800, 16'hFFFF);
    send(12'd2047, 12'd2047, 16'hFFFF);
    send(12'd2047, 12'h800, 16'hFFFF);
    drain();

    configure(11'd1000, 11'd1000, 16'd46080);
    send(12'd1000, 12'd2000, 16'hFFFF);
    send(12'd0, 12'd1000, 16'hFFFF);
    send(12'd1000, 12'd0, 16'd500);
    drain();

    // Random part: one setting per phase, extremes among them.
    configure(11'($urandom), 11'($urandom), 16'($urandom_range(46080)));
    random_phase(PHASE_ITEMS, 0, 0);
    drain();
    configure(11'd0, 11'd2047, 16'hFFFF);
    random_phase(PHASE_ITEMS, 0, 0);
    drain();
    configure(11'd2047, 11'd0, 16'd0);
    random_phase(PHASE_ITEMS, 0, 0);
    drain();
    configure(11'($urandom), 11'($urandom), 16'($urandom));
    random_phase(PHASE_ITEMS, 30, 150);      // long stretch with no idling
    drain();
    configure(11'd2047, 11'd2047, 16'd46080);
    random_phase(PHASE_ITEMS, 0, 0);
    drain();
    configure(11'($urandom), 11'($urandom), 16'($urandom_range(8000)));
    random_phase(PHASE_ITEMS, 0, 0);

    // Let any stray result show up before the verdict.
    drain();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
